// ===== sv/metb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// metb_pkg - shared types for the mesh edge table builder
// Request codes, request/result payload structs and the edge entry layout.
// ----------------------------------------------------------------------------
package metb_pkg;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [9:0] vert_a;
    logic [9:0] vert_b;
    logic [9:0] vert_c;
    logic [8:0] entry_index;
  } in_item_t;

  typedef struct packed {
    logic [8:0] edge_ab;
    logic [8:0] edge_bc;
    logic [8:0] edge_ca;
    logic [9:0] edge_count;
    logic       overflow;
    logic [9:0] rd_vert_first;
    logic [9:0] rd_vert_second;
    logic [7:0] rd_face_first;
    logic [7:0] rd_face_second;
    logic       rd_shared;
  } out_item_t;

  // One stored edge, kept as a single memory word.
  typedef struct packed {
    logic [9:0] vert_first;
    logic [9:0] vert_second;
    logic [7:0] face_first;
    logic [7:0] face_second;
    logic       shared;
  } entry_t;

endpackage

// ===== sv/mesh_edge_table_builder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_edge_table_builder_core - unique edge table from a triangle stream
// Clears the table, adds triangles (edge lookup or append) and reads entries.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload  | carries
//  ---------+-----------------------+----------+----------------------------------------
//  request  | in_valid / in_ready   | in_data  | clear / add triangle / read entry
//  result   | out_valid / out_ready | out_data | edge indices, count, overflow, entry fields
//
// Scans: an add request scans the stored edges once per triangle edge, one
//   memory read per cycle, until a match or the end of the stored edges.
// The single read port of the edge memory sets that pace.
// Reset clears the edge and triangle counts; memory contents are left as is
//   and only entries below the count ever reach a result.
// A request is taken while the previous result still waits downstream; the
//   finished result then holds in the sequencer until the output frees up.
// ----------------------------------------------------------------------------
module mesh_edge_table_builder_core #(
  parameter int EDGE_DEPTH    = 512,
  parameter int MAX_TRIANGLES = 256,
  parameter int MAX_VERTICES  = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  metb_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output metb_pkg::out_item_t   out_data
);
  import metb_pkg::*;

  localparam int AW = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;
  localparam int CW = $clog2(EDGE_DEPTH + 1);
  localparam int TW = $clog2(MAX_TRIANGLES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_DONE
  } state_t;

  state_t          state;
  in_item_t        req;
  out_item_t       res;
  out_item_t       res_init;   // result seed for a newly taken request
  out_item_t       res_out;    // finished result with the current count
  logic [1:0]      k;          // which triangle edge is being placed
  logic [CW-1:0]   ptr;        // next entry to read during a scan
  logic            pend;       // a scan read is in flight
  logic [AW-1:0]   pend_addr;  // address of that read
  logic [CW-1:0]   edge_total;
  logic [TW-1:0]   tri_total;

  // Memory ports
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  entry_t          mem_wdata;
  logic [AW-1:0]   mem_raddr;
  entry_t          mem_rdata;

  // Scan datapath
  logic [9:0]      v1;
  logic [9:0]      v2;
  logic [7:0]      face;
  logic            issue;
  logic            hit;
  logic            miss_end;
  logic            full;
  logic [AW-1:0]   cur_idx;
  logic            tri_drop;
  logic            rd_in_range;

  metb_ram #(
    .DEPTH (EDGE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ready = (state == S_IDLE);

  // Select the vertex pair of the current triangle edge.
  always_comb begin
    case (k)
      2'd0: begin
        v1 = req.vert_a;
        v2 = req.vert_b;
      end
      2'd1: begin
        v1 = req.vert_b;
        v2 = req.vert_c;
      end
      default: begin
        v1 = req.vert_c;
        v2 = req.vert_a;
      end
    endcase
  end

  assign face = 8'(tri_total);
  assign full = (32'(edge_total) >= EDGE_DEPTH);

  // Issue one read per cycle until every stored edge has been requested.
  assign issue = (state == S_SCAN) && (ptr < edge_total);

  // Match in either vertex order against the word that just came back.
  assign hit = (state == S_SCAN) && pend &&
               (((mem_rdata.vert_first == v1) && (mem_rdata.vert_second == v2)) ||
                ((mem_rdata.vert_second == v1) && (mem_rdata.vert_first == v2)));

  // Scan exhausted with nothing left in flight: the edge is new.
  assign miss_end = (state == S_SCAN) && !pend && (ptr >= edge_total);

  assign cur_idx = hit ? pend_addr : (full ? '0 : edge_total[AW-1:0]);

  // Drop the whole triangle when the face counter is used up or a vertex
  // lies outside the mesh.
  assign tri_drop = (32'(tri_total) >= MAX_TRIANGLES) ||
                    (32'(in_data.vert_a) >= MAX_VERTICES) ||
                    (32'(in_data.vert_b) >= MAX_VERTICES) ||
                    (32'(in_data.vert_c) >= MAX_VERTICES);

  assign rd_in_range = (32'(req.entry_index) < 32'(edge_total)) &&
                       (32'(req.entry_index) < EDGE_DEPTH);

  // Start every result at zero; a dropped triangle only raises overflow.
  always_comb begin
    res_init          = '0;
    res_init.overflow = (in_data.req_type == REQ_ADD) && tri_drop;
  end

  // Stamp the edge count as it stands when the result is handed over.
  always_comb begin
    res_out            = res;
    res_out.edge_count = 10'(edge_total);
  end

  // Read the request's entry straight from the input while idle so the
  // word is ready in the cycle after acceptance.
  assign mem_raddr = (state == S_IDLE) ? AW'(in_data.entry_index) : ptr[AW-1:0];

  // Write back on a hit (mark shared), or append on a miss with room left.
  always_comb begin
    mem_we    = hit || (miss_end && !full);
    mem_waddr = hit ? pend_addr : edge_total[AW-1:0];
    if (hit) begin
      mem_wdata             = mem_rdata;
      mem_wdata.face_second = face;
      mem_wdata.shared      = 1'b1;
    end else begin
      mem_wdata.vert_first  = v1;
      mem_wdata.vert_second = v2;
      mem_wdata.face_first  = face;
      mem_wdata.face_second = '0;
      mem_wdata.shared      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      pend       <= 1'b0;
      edge_total <= '0;
      tri_total  <= '0;
    end else begin
      // Raise the result when the sequencer hands one over; drop it once taken.
      if ((state == S_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req  <= in_data;
            res  <= res_init;
            k    <= '0;
            ptr  <= '0;
            pend <= 1'b0;
            case (in_data.req_type)
              REQ_CLEAR: begin
                edge_total <= '0;
                tri_total  <= '0;
                state      <= S_DONE;
              end
              REQ_ADD: begin
                if (tri_drop) begin
                  state <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              REQ_READ: begin
                state <= S_READ;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          pend_addr <= ptr[AW-1:0];
          if (hit || miss_end) begin
            case (k)
              2'd0:    res.edge_ab <= 9'(cur_idx);
              2'd1:    res.edge_bc <= 9'(cur_idx);
              default: res.edge_ca <= 9'(cur_idx);
            endcase
            if (miss_end && full) begin
              res.overflow <= 1'b1;
            end
            if (miss_end && !full) begin
              edge_total <= edge_total + 1'b1;
            end
            // Restart the scan for the next edge; drop any read in flight.
            ptr  <= '0;
            pend <= 1'b0;
            k    <= k + 1'b1;
            if (k == 2'd2) begin
              tri_total <= tri_total + 1'b1;
              state     <= S_DONE;
            end
          end else begin
            pend <= issue;
            if (issue) begin
              ptr <= ptr + 1'b1;
            end
          end
        end
        S_READ: begin
          if (rd_in_range) begin
            res.rd_vert_first  <= mem_rdata.vert_first;
            res.rd_vert_second <= mem_rdata.vert_second;
            res.rd_face_first  <= mem_rdata.face_first;
            res.rd_face_second <= mem_rdata.face_second;
            res.rd_shared      <= mem_rdata.shared;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          // Hold the result until the output register is free.
          if (!out_valid || out_ready) begin
            out_data <= res_out;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The edge count never passes the table depth.
  a_edge_bound: assert property (@(posedge clk) disable iff (rst)
    32'(edge_total) <= EDGE_DEPTH)
    else $error("edge count beyond table depth");

  // The face counter never passes its limit.
  a_tri_bound: assert property (@(posedge clk) disable iff (rst)
    32'(tri_total) <= MAX_TRIANGLES)
    else $error("triangle count beyond limit");

  // A scan never reads past the stored edges.
  a_scan_ptr: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (ptr <= edge_total))
    else $error("scan pointer past edge count");

  // A clear empties the table on the next cycle.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_data.req_type == REQ_CLEAR)) |=>
      ((edge_total == '0) && (tri_total == '0)))
    else $error("clear did not empty the table");

endmodule

// ===== sv/metb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// metb_ram - edge entry memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module metb_ram #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  metb_pkg::entry_t     wdata,
  input  logic [AW-1:0]        raddr,
  output metb_pkg::entry_t     rdata
);
  import metb_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
